@@ hw/rtl/kmeans_pkg.sv @@
package kmeans_pkg;

    // Field widths fixed by the item format
    localparam int VALUE_W   = 24;
    localparam int CID_W     = 3;
    localparam int COORD_W   = 4;
    localparam int OCOUNT_W  = 20;
    localparam int CFG_K_W   = 4;
    localparam int CFG_D_W   = 5;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    // Defaults for the top level parameters
    localparam int DEF_MAX_CLUSTERS  = 8;
    localparam int DEF_MAX_DIMENSION = 16;
    localparam int DEF_COUNT_BITS    = 20;

    // Register reset values
    localparam logic [CFG_K_W-1:0] CFG_K_RESET = 4'd2;
    localparam logic [CFG_D_W-1:0] CFG_D_RESET = 5'd2;

    // Register indexes (paddr[2])
    localparam logic REG_CLUSTERS  = 1'b0;
    localparam logic REG_DIMENSION = 1'b1;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_POINT = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_QUERY = 2'd3
    } mode_t;

    localparam logic KIND_CLASS = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

endpackage

@@ hw/rtl/kmeans_ram.sv @@
module kmeans_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/kmeans_assign_accumulate_top.sv @@
// Channel   Signals                                        Direction
// item      item_valid/item_stall, mode, cluster_index,    in
//           coord_index, value
// result    result_valid/result_stall, kind, cluster_id,   out
//           average, member_count, empty_flag
// config    psel/penable/pwrite/paddr/pwdata/prdata/pready  APB
//
// A point coordinate passes through the shared subtract/square/accumulate
// unit, which visits one cluster in use at a time (read, difference, square,
// accumulate). The last coordinate adds a compare over the clusters in use,
// one count update, a read and a write of each of the MAX_DIMENSION sum-row
// entries on the sum RAM (skipped once the count saturates) and a hand-off
// of the result. A query reads the sum row and, for a non-empty cluster,
// runs the bit-serial divider. No clearing pass after reset: sum rows carry
// valid bits. item_stall is high while an item is in work or while a result
// waits behind result_stall.
module kmeans_assign_accumulate_top #(
    parameter int MAX_CLUSTERS  = kmeans_pkg::DEF_MAX_CLUSTERS,
    parameter int MAX_DIMENSION = kmeans_pkg::DEF_MAX_DIMENSION,
    parameter int COUNT_BITS    = kmeans_pkg::DEF_COUNT_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // item channel
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic [1:0]                          mode,
    input  logic [kmeans_pkg::CID_W-1:0]        cluster_index,
    input  logic [kmeans_pkg::COORD_W-1:0]      coord_index,
    input  logic signed [kmeans_pkg::VALUE_W-1:0] value,
    // result channel
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic                                kind,
    output logic [kmeans_pkg::CID_W-1:0]        cluster_id,
    output logic signed [kmeans_pkg::VALUE_W-1:0] average,
    output logic [kmeans_pkg::OCOUNT_W-1:0]     member_count,
    output logic                                empty_flag,
    // config port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [kmeans_pkg::PADDR_W-1:0]      paddr,
    input  logic [kmeans_pkg::PDATA_W-1:0]      pwdata,
    output logic [kmeans_pkg::PDATA_W-1:0]      prdata,
    output logic                                pready
);

    localparam int VW    = kmeans_pkg::VALUE_W;
    localparam int CI_W  = $clog2(MAX_CLUSTERS);
    localparam int DI_W  = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1;
    localparam int DEPTH = MAX_CLUSTERS * MAX_DIMENSION;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W = VW + COUNT_BITS;
    localparam int SQ_W  = 2 * VW;
    localparam int PD_W  = SQ_W + 2 + $clog2(MAX_DIMENSION + 1);
    localparam int DC_W  = $clog2(SUM_W + 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_PT_RD   = 11'b000_0000_0010,
        S_PT_DIFF = 11'b000_0000_0100,
        S_PT_SQR  = 11'b000_0000_1000,
        S_PT_ACC  = 11'b000_0001_0000,
        S_CMP     = 11'b000_0010_0000,
        S_CNT     = 11'b000_0100_0000,
        S_SUM_RD  = 11'b000_1000_0000,
        S_SUM_WR  = 11'b001_0000_0000,
        S_Q_RD    = 11'b010_0000_0000,
        S_DIV     = 11'b100_0000_0000
    } state_t;

    // S_DONE is folded into a flag so the enum stays at eleven codes
    state_t state_reg;
    logic   done_reg;

    logic [kmeans_pkg::CFG_K_W-1:0] cfg_k_reg;
    logic [kmeans_pkg::CFG_D_W-1:0] cfg_d_reg;

    logic [1:0]          mode_reg;
    logic [CI_W-1:0]     ci_reg;
    logic signed [VW-1:0] val_reg;
    logic [DI_W-1:0]     pos_reg;
    logic [DI_W-1:0]     cc_reg;
    logic [CI_W-1:0]     c_reg;
    logic [DI_W-1:0]     j_reg;
    logic [CI_W-1:0]     best_reg;
    logic [PD_W-1:0]     bestd_reg;
    logic signed [VW:0]  diff_reg;
    logic [SQ_W-1:0]     sq_reg;
    logic [PD_W-1:0]     pd_reg [MAX_CLUSTERS];
    logic [COUNT_BITS-1:0] cnt_reg [MAX_CLUSTERS];
    logic                rowv_reg [MAX_CLUSTERS];
    logic [SUM_W-1:0]    dvd_reg;
    logic [COUNT_BITS-1:0] rem_reg;
    logic                neg_reg;
    logic [DC_W-1:0]     dcnt_reg;
    logic signed [VW-1:0] avg_reg;

    logic                res_valid_reg;
    logic                res_kind_reg;
    logic [kmeans_pkg::CID_W-1:0] res_cid_reg;
    logic signed [VW-1:0] res_avg_reg;
    logic [kmeans_pkg::OCOUNT_W-1:0] res_cnt_reg;
    logic                res_empty_reg;

    // Effective register values
    logic [7:0] k_eff;
    logic [7:0] d_eff;
    always_comb
    begin
        if (cfg_k_reg == '0)
            k_eff = 8'd1;
        else if (int'(cfg_k_reg) > MAX_CLUSTERS)
            k_eff = 8'(MAX_CLUSTERS);
        else
            k_eff = 8'(cfg_k_reg);
        if (cfg_d_reg == '0)
            d_eff = 8'd1;
        else if (int'(cfg_d_reg) > MAX_DIMENSION)
            d_eff = 8'(MAX_DIMENSION);
        else
            d_eff = 8'(cfg_d_reg);
    end

    logic item_fire;
    logic cfg_we;
    logic idx_ok;
    logic [DI_W-1:0] pos_in;
    assign item_stall = (state_reg != S_IDLE) || done_reg;
    assign item_fire  = item_valid && !item_stall;
    assign cfg_we     = psel && penable && pwrite;
    assign idx_ok     = (int'(cluster_index) < MAX_CLUSTERS) &&
                        (int'(coord_index) < MAX_DIMENSION);
    assign pos_in     = (int'(cc_reg) >= int'(d_eff)) ? '0 : cc_reg;

    // Memories
    logic            cen_we;
    logic [AW-1:0]   cen_waddr;
    logic [AW-1:0]   cen_raddr;
    logic [VW-1:0]   cen_rdata;
    logic            pt_we;
    logic [DI_W-1:0] pt_raddr;
    logic [VW-1:0]   pt_rdata;
    logic            sum_we;
    logic [AW-1:0]   sum_addr;
    logic [SUM_W-1:0] sum_wdata;
    logic [SUM_W-1:0] sum_rdata;
    logic [AW-1:0]   q_addr;

    assign cen_we    = item_fire && (mode == kmeans_pkg::MODE_LOAD) && idx_ok;
    assign cen_waddr = AW'(int'(cluster_index) * MAX_DIMENSION + int'(coord_index));
    assign cen_raddr = AW'(int'(c_reg) * MAX_DIMENSION + int'(pos_reg));
    assign pt_we     = item_fire && (mode == kmeans_pkg::MODE_POINT);
    assign pt_raddr  = j_reg;
    assign sum_addr  = AW'(int'(best_reg) * MAX_DIMENSION + int'(j_reg));
    assign q_addr    = AW'(int'(cluster_index) * MAX_DIMENSION + int'(coord_index));
    assign sum_we    = (state_reg == S_SUM_WR);

    // Sum row update: an invalid row reads as zero, coordinates past d add zero
    logic [SUM_W-1:0] sum_old;
    logic [SUM_W-1:0] sum_add;
    always_comb
    begin
        sum_old   = rowv_reg[best_reg] ? sum_rdata : '0;
        sum_add   = (int'(j_reg) < int'(d_eff)) ?
                    {{(SUM_W-VW){pt_rdata[VW-1]}}, pt_rdata} : '0;
        sum_wdata = sum_old + sum_add;
    end

    kmeans_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_cen_ram (
        .clk   (clk),
        .we    (cen_we),
        .waddr (cen_waddr),
        .wdata (value),
        .raddr (cen_raddr),
        .rdata (cen_rdata)
    );

    kmeans_ram #(.WIDTH(VW), .DEPTH(MAX_DIMENSION), .AW(DI_W)) u_pt_ram (
        .clk   (clk),
        .we    (pt_we),
        .waddr (pos_in),
        .wdata (value),
        .raddr (pt_raddr),
        .rdata (pt_rdata)
    );

    kmeans_ram #(.WIDTH(SUM_W), .DEPTH(DEPTH)) u_sum_ram (
        .clk   (clk),
        .we    (sum_we),
        .waddr (sum_addr),
        .wdata (sum_wdata),
        .raddr ((state_reg == S_IDLE) ? q_addr : sum_addr),
        .rdata (sum_rdata)
    );

    // Shared unit: magnitude of the difference and its square
    logic [VW-1:0] mag;
    assign mag = diff_reg[VW] ? VW'(-diff_reg) : VW'(diff_reg);

    // Divider step: restoring, one quotient bit per cycle
    logic [COUNT_BITS:0]   rem_sh;
    logic [COUNT_BITS:0]   rem_diff;
    logic                  qbit;
    logic [SUM_W-1:0]      q_next;
    logic [COUNT_BITS-1:0] divisor;
    always_comb
    begin
        divisor  = cnt_reg[ci_reg];
        rem_sh   = {rem_reg, dvd_reg[SUM_W-1]};
        rem_diff = rem_sh - {1'b0, divisor};
        qbit     = (rem_sh >= {1'b0, divisor});
        q_next   = {dvd_reg[SUM_W-2:0], qbit};
    end

    logic [SUM_W-1:0] q_signed;
    assign q_signed = neg_reg ? (-q_next) : q_next;

    logic [SUM_W-1:0] sum_q;
    assign sum_q = rowv_reg[ci_reg] ? sum_rdata : '0;

    // Control and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            done_reg      <= 1'b0;
            cfg_k_reg     <= kmeans_pkg::CFG_K_RESET;
            cfg_d_reg     <= kmeans_pkg::CFG_D_RESET;
            cc_reg        <= '0;
            c_reg         <= '0;
            j_reg         <= '0;
            dcnt_reg      <= '0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_CLUSTERS; i++)
            begin
                pd_reg[i]   <= '0;
                cnt_reg[i]  <= '0;
                rowv_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (res_valid_reg && !result_stall && !done_reg)
            begin
                res_valid_reg <= 1'b0;
            end

            // Register write discards a partial point
            if (cfg_we)
            begin
                if (paddr[2] == kmeans_pkg::REG_CLUSTERS)
                    cfg_k_reg <= pwdata[kmeans_pkg::CFG_K_W-1:0];
                else
                    cfg_d_reg <= pwdata[kmeans_pkg::CFG_D_W-1:0];
                cc_reg <= '0;
                for (int i = 0; i < MAX_CLUSTERS; i++)
                    pd_reg[i] <= '0;
            end

            // Finished result goes out once the output register is free
            if (done_reg && (!res_valid_reg || !result_stall))
            begin
                done_reg      <= 1'b0;
                res_valid_reg <= 1'b1;
                if (mode_reg == kmeans_pkg::MODE_POINT)
                begin
                    res_kind_reg  <= kmeans_pkg::KIND_CLASS;
                    res_cid_reg   <= kmeans_pkg::CID_W'(best_reg);
                    res_avg_reg   <= '0;
                    res_cnt_reg   <= kmeans_pkg::OCOUNT_W'(cnt_reg[best_reg]);
                    res_empty_reg <= 1'b0;
                end
                else
                begin
                    res_kind_reg  <= kmeans_pkg::KIND_QUERY;
                    res_cid_reg   <= kmeans_pkg::CID_W'(ci_reg);
                    res_avg_reg   <= avg_reg;
                    res_cnt_reg   <= kmeans_pkg::OCOUNT_W'(cnt_reg[ci_reg]);
                    res_empty_reg <= (cnt_reg[ci_reg] == '0);
                end
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (item_fire)
                    begin
                        mode_reg <= mode;
                        ci_reg   <= CI_W'(cluster_index);
                        val_reg  <= value;
                        unique case (mode)
                            kmeans_pkg::MODE_LOAD:
                            begin
                                // write done by the centroid RAM port
                            end
                            kmeans_pkg::MODE_CLEAR:
                            begin
                                cc_reg <= '0;
                                for (int i = 0; i < MAX_CLUSTERS; i++)
                                begin
                                    pd_reg[i]   <= '0;
                                    cnt_reg[i]  <= '0;
                                    rowv_reg[i] <= 1'b0;
                                end
                            end
                            kmeans_pkg::MODE_QUERY:
                            begin
                                if (idx_ok)
                                    state_reg <= S_Q_RD;
                            end
                            kmeans_pkg::MODE_POINT:
                            begin
                                pos_reg   <= pos_in;
                                c_reg     <= '0;
                                state_reg <= S_PT_RD;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end

                S_PT_RD:
                begin
                    state_reg <= S_PT_DIFF;
                end

                S_PT_DIFF:
                begin
                    diff_reg  <= {val_reg[VW-1], val_reg} -
                                 {cen_rdata[VW-1], cen_rdata};
                    state_reg <= S_PT_SQR;
                end

                S_PT_SQR:
                begin
                    sq_reg    <= mag * mag;
                    state_reg <= S_PT_ACC;
                end

                S_PT_ACC:
                begin
                    pd_reg[c_reg] <= pd_reg[c_reg] + PD_W'(sq_reg);
                    if (int'(c_reg) + 1 < int'(k_eff))
                    begin
                        c_reg     <= c_reg + 1'b1;
                        state_reg <= S_PT_RD;
                    end
                    else if (int'(pos_reg) + 1 < int'(d_eff))
                    begin
                        cc_reg    <= pos_reg + 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        c_reg     <= '0;
                        state_reg <= S_CMP;
                    end
                end

                // Scan for the smallest distance, lowest index wins ties
                S_CMP:
                begin
                    if ((c_reg == '0) || (pd_reg[c_reg] < bestd_reg))
                    begin
                        best_reg  <= c_reg;
                        bestd_reg <= pd_reg[c_reg];
                    end
                    if (int'(c_reg) + 1 < int'(k_eff))
                    begin
                        c_reg <= c_reg + 1'b1;
                    end
                    else
                    begin
                        state_reg <= S_CNT;
                    end
                end

                S_CNT:
                begin
                    cc_reg <= '0;
                    for (int i = 0; i < MAX_CLUSTERS; i++)
                        pd_reg[i] <= '0;
                    j_reg <= '0;
                    if (cnt_reg[best_reg] != COUNT_MAX)
                    begin
                        cnt_reg[best_reg] <= cnt_reg[best_reg] + 1'b1;
                        state_reg         <= S_SUM_RD;
                    end
                    else
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end

                S_SUM_RD:
                begin
                    state_reg <= S_SUM_WR;
                end

                S_SUM_WR:
                begin
                    if (int'(j_reg) == MAX_DIMENSION - 1)
                    begin
                        rowv_reg[best_reg] <= 1'b1;
                        done_reg           <= 1'b1;
                        state_reg          <= S_IDLE;
                    end
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_SUM_RD;
                    end
                end

                S_Q_RD:
                begin
                    rem_reg  <= '0;
                    dcnt_reg <= '0;
                    neg_reg  <= sum_q[SUM_W-1];
                    dvd_reg  <= sum_q[SUM_W-1] ? (-sum_q) : sum_q;
                    if (cnt_reg[ci_reg] == '0)
                    begin
                        avg_reg   <= '0;
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_DIV;
                    end
                end

                S_DIV:
                begin
                    rem_reg  <= qbit ? rem_diff[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
                    dvd_reg  <= q_next;
                    dcnt_reg <= dcnt_reg + 1'b1;
                    if (int'(dcnt_reg) == SUM_W - 1)
                    begin
                        avg_reg   <= q_signed[VW-1:0];
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Register read-back
    always_comb
    begin
        unique case (paddr[2])
            kmeans_pkg::REG_CLUSTERS:  prdata = kmeans_pkg::PDATA_W'(cfg_k_reg);
            kmeans_pkg::REG_DIMENSION: prdata = kmeans_pkg::PDATA_W'(cfg_d_reg);
            default:                   prdata = '0;
        endcase
    end

    assign pready       = 1'b1;
    assign result_valid = res_valid_reg;
    assign kind         = res_kind_reg;
    assign cluster_id   = res_cid_reg;
    assign average      = res_avg_reg;
    assign member_count = res_cnt_reg;
    assign empty_flag   = res_empty_reg;

endmodule
